### rtl/cpu6502_subset_core_defines.svh
// Assertion macros for the cpu6502 subset core.
// No dependencies; included by files that carry assertions.
`ifndef CPU6502_SUBSET_CORE_DEFINES_SVH
`define CPU6502_SUBSET_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define C6502_ASSERT_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("c6502 assertion failed");
`define C6502_ASSERT_NXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("c6502 assertion failed");
`else
`define C6502_ASSERT_IMP(lbl, clk, rst, a, c)
`define C6502_ASSERT_NXT(lbl, clk, rst, a, c)
`endif
`endif

### rtl/c6502_pkg.sv
// Shared types, constants and the opcode decode function of the cpu6502 subset core.
// No dependencies.
package c6502_pkg;

  localparam int unsigned MEM_BYTES_DEF = 65536;
  localparam logic [15:0] START_RST = 16'hFFFC;
  localparam logic [7:0]  SP_RST = 8'hFF;
  localparam logic [7:0]  STACK_PAGE = 8'h01;

  localparam int F_C = 0;
  localparam int F_Z = 1;
  localparam int F_I = 2;
  localparam int F_D = 3;
  localparam int F_RUN = 5;
  localparam int F_V = 6;
  localparam int F_N = 7;

  localparam logic CFG_START = 1'b0;
  localparam logic CFG_SP = 1'b1;

  localparam logic [2:0] GRP_AND = 3'b001;
  localparam logic [2:0] GRP_ADC = 3'b011;
  localparam logic [1:0] GRP_ALU = 2'b01;
  localparam logic [7:0] OP_JMP = 8'h4C;
  localparam logic [7:0] OP_JMPI = 8'h6C;
  localparam logic [7:0] OP_JSR = 8'h20;
  localparam logic [7:0] OP_RTS = 8'h60;
  localparam logic [7:0] OP_LDA = 8'hA9;
  localparam logic [7:0] OP_LDX = 8'hA2;
  localparam logic [7:0] OP_LDY = 8'hA0;
  localparam logic [7:0] OP_CLC = 8'h18;
  localparam logic [7:0] OP_SEC = 8'h38;
  localparam logic [7:0] OP_CLI = 8'h58;
  localparam logic [7:0] OP_SEI = 8'h78;
  localparam logic [7:0] OP_CLV = 8'hB8;
  localparam logic [7:0] OP_CLD = 8'hD8;
  localparam logic [7:0] OP_SED = 8'hF8;
  localparam logic [7:0] OP_NOP = 8'hEA;
  localparam logic [7:0] OP_BRK = 8'h00;

  typedef enum logic [1:0] {ACT_WR = 2'd0, ACT_RD = 2'd1, ACT_EXEC = 2'd2,
                            ACT_NONE = 2'd3} action_t;

  typedef enum logic [4:0] {
    K_AND, K_ADC, K_JMP, K_JMPI, K_JSR, K_RTS, K_LDA, K_LDX, K_LDY,
    K_CLC, K_SEC, K_CLI, K_SEI, K_CLV, K_CLD, K_SED, K_NOP, K_BRK, K_BAD
  } kind_t;

  typedef enum logic [2:0] {
    M_INX = 3'd0, M_ZP = 3'd1, M_IMM = 3'd2, M_ABS = 3'd3,
    M_INY = 3'd4, M_ZPX = 3'd5, M_ABY = 3'd6, M_ABX = 3'd7
  } mode_t;

  typedef enum logic [4:0] {
    S_IDLE, S_ACT, S_RDW, S_OP, S_B1, S_B2, S_ADR, S_P1, S_P2, S_P3,
    S_M, S_J1, S_J2, S_JSR2, S_R1, S_R2, S_EXEC, S_OUT
  } state_t;

  typedef enum logic [3:0] {
    A_IN, A_PC, A_PC1, A_PC2, A_ZP, A_ZP1, A_ZPX, A_ZPX1, A_W, A_W1,
    A_WX, A_WY, A_STK, A_STK1, A_STK2
  } addr_sel_t;

  typedef enum logic [1:0] {WR_IN, WR_PCH, WR_PCL} wr_sel_t;

  typedef enum logic [1:0] {PC_HOLD, PC_W, PC_RL, PC_RL1} pc_sel_t;

  typedef struct packed {
    logic      ld_in;
    logic      mem_we;
    addr_sel_t addr_sel;
    wr_sel_t   wr_sel;
    logic      ld_op;
    logic      ld_b1;
    logic      ld_wb;
    logic      ld_lo;
    logic      ld_wl;
    logic      ld_m;
    logic      ld_rd;
    logic      sp_dec;
    logic      sp_pop2;
    pc_sel_t   pc_sel;
    logic      exec;
  } cmd_t;

  typedef struct packed {
    action_t action;
    kind_t   kind;
    mode_t   mode;
    logic    stopped;
  } stat_t;

  typedef struct packed {
    logic [7:0]  acc;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  sp;
    logic [15:0] pc;
    logic [7:0]  status;
    logic        halted;
    logic        bad;
    logic [7:0]  rd;
  } res_t;

  function automatic kind_t op_kind(input logic [7:0] op);
    kind_t k;
    k = K_BAD;
    if (op[1:0] == GRP_ALU && op[7:5] == GRP_AND) k = K_AND;
    else if (op[1:0] == GRP_ALU && op[7:5] == GRP_ADC) k = K_ADC;
    else begin
      case (op)
        OP_JMP:  k = K_JMP;
        OP_JMPI: k = K_JMPI;
        OP_JSR:  k = K_JSR;
        OP_RTS:  k = K_RTS;
        OP_LDA:  k = K_LDA;
        OP_LDX:  k = K_LDX;
        OP_LDY:  k = K_LDY;
        OP_CLC:  k = K_CLC;
        OP_SEC:  k = K_SEC;
        OP_CLI:  k = K_CLI;
        OP_SEI:  k = K_SEI;
        OP_CLV:  k = K_CLV;
        OP_CLD:  k = K_CLD;
        OP_SED:  k = K_SED;
        OP_NOP:  k = K_NOP;
        OP_BRK:  k = K_BRK;
        default: k = K_BAD;
      endcase
    end
    return k;
  endfunction

endpackage

### rtl/c6502_if.sv
// Valid/ready channel interfaces for item and result words.
// Depends on nothing.
interface c6502_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] mem_address;
  logic [7:0]  mem_data;
  modport source (output valid, action, mem_address, mem_data, input ready);
  modport sink (input valid, action, mem_address, mem_data, output ready);
endinterface

interface c6502_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  acc_value;
  logic [7:0]  x_value;
  logic [7:0]  y_value;
  logic [7:0]  stack_value;
  logic [15:0] pc_value;
  logic [7:0]  status_byte;
  logic        halted;
  logic        bad_opcode;
  logic [7:0]  read_data;
  modport source (output valid, acc_value, x_value, y_value, stack_value, pc_value,
                  status_byte, halted, bad_opcode, read_data, input ready);
  modport sink (input valid, acc_value, x_value, y_value, stack_value, pc_value,
                status_byte, halted, bad_opcode, read_data, output ready);
endinterface

### rtl/c6502_ctrl.sv
// Sequencer of the cpu6502 subset core: state machine issuing datapath commands.
// Depends on c6502_pkg.
module c6502_ctrl
  import c6502_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t st,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_ACT;
      S_ACT: begin
        unique case (st.action)
          ACT_WR:   state_next = S_OUT;
          ACT_RD:   state_next = S_RDW;
          ACT_EXEC: state_next = st.stopped ? S_OUT : S_OP;
          default:  state_next = S_OUT;
        endcase
      end
      S_RDW: state_next = S_OUT;
      S_OP:  state_next = S_B1;
      S_B1:  state_next = S_B2;
      S_B2:  state_next = S_ADR;
      S_ADR: begin
        unique case (st.kind)
          K_AND, K_ADC: begin
            unique case (st.mode)
              M_IMM:        state_next = S_EXEC;
              M_INX, M_INY: state_next = S_P1;
              default:      state_next = S_M;
            endcase
          end
          K_JMP:   state_next = S_OUT;
          K_JMPI:  state_next = S_J1;
          K_JSR:   state_next = S_JSR2;
          K_RTS:   state_next = S_R1;
          default: state_next = S_EXEC;
        endcase
      end
      S_P1:   state_next = S_P2;
      S_P2:   state_next = S_P3;
      S_P3:   state_next = S_M;
      S_M:    state_next = S_EXEC;
      S_J1:   state_next = S_J2;
      S_J2:   state_next = S_OUT;
      S_JSR2: state_next = S_OUT;
      S_R1:   state_next = S_R2;
      S_R2:   state_next = S_OUT;
      S_EXEC: state_next = S_OUT;
      S_OUT:  if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.ld_in = in_valid;
      end
      S_ACT: begin
        cmd.addr_sel = (st.action == ACT_EXEC) ? A_PC : A_IN;
        cmd.wr_sel = WR_IN;
        cmd.mem_we = (st.action == ACT_WR);
      end
      S_RDW: cmd.ld_rd = 1'b1;
      S_OP: begin
        cmd.ld_op = 1'b1;
        cmd.addr_sel = A_PC1;
      end
      S_B1: begin
        cmd.ld_b1 = 1'b1;
        cmd.addr_sel = A_PC2;
      end
      S_B2: cmd.ld_wb = 1'b1;
      S_ADR: begin
        unique case (st.kind)
          K_AND, K_ADC: begin
            unique case (st.mode)
              M_ZP, M_INY:  cmd.addr_sel = A_ZP;
              M_ZPX, M_INX: cmd.addr_sel = A_ZPX;
              M_ABX:        cmd.addr_sel = A_WX;
              M_ABY:        cmd.addr_sel = A_WY;
              default:      cmd.addr_sel = A_W;
            endcase
          end
          K_JMP:  cmd.pc_sel = PC_W;
          K_JMPI: cmd.addr_sel = A_W;
          K_JSR: begin
            cmd.addr_sel = A_STK;
            cmd.wr_sel = WR_PCH;
            cmd.mem_we = 1'b1;
            cmd.sp_dec = 1'b1;
          end
          K_RTS:   cmd.addr_sel = A_STK1;
          default: cmd.addr_sel = A_PC;
        endcase
      end
      S_P1: begin
        cmd.ld_lo = 1'b1;
        cmd.addr_sel = (st.mode == M_INX) ? A_ZPX1 : A_ZP1;
      end
      S_P2: cmd.ld_wl = 1'b1;
      S_P3: cmd.addr_sel = (st.mode == M_INX) ? A_W : A_WY;
      S_M:  cmd.ld_m = 1'b1;
      S_J1: begin
        cmd.ld_lo = 1'b1;
        cmd.addr_sel = A_W1;
      end
      S_J2: cmd.pc_sel = PC_RL;
      S_JSR2: begin
        cmd.addr_sel = A_STK;
        cmd.wr_sel = WR_PCL;
        cmd.mem_we = 1'b1;
        cmd.sp_dec = 1'b1;
        cmd.pc_sel = PC_W;
      end
      S_R1: begin
        cmd.ld_lo = 1'b1;
        cmd.addr_sel = A_STK2;
      end
      S_R2: begin
        cmd.pc_sel = PC_RL1;
        cmd.sp_pop2 = 1'b1;
      end
      S_EXEC: cmd.exec = 1'b1;
      S_OUT:  out_valid = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

### rtl/c6502_dp.sv
// Datapath of the cpu6502 subset core: registers, byte memory, ALU, config regs.
// Depends on c6502_pkg.
module c6502_dp
  import c6502_pkg::*;
#(
  parameter int unsigned MEM_BYTES = MEM_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       st,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_data,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [15:0] cfg_data,
  output logic [15:0] cfg_rd,
  output res_t        res
);

  localparam int AW = $clog2(MEM_BYTES);

  logic [7:0]  mem [MEM_BYTES];
  logic [7:0]  rdata;
  logic [15:0] maddr;
  logic [7:0]  wdata;

  logic [7:0]  a, x, y, sp, p, op, b1, lo, m, rd;
  logic [15:0] pc, w, start_addr, pc2;
  logic [7:0]  isp;
  logic        stopped, bad;
  logic [1:0]  act;
  logic [15:0] iaddr;
  logic [7:0]  idata;

  kind_t      kind;
  mode_t      mode;
  logic [7:0] opnd, alu;
  logic [8:0] sum;
  logic [15:0] len;

  assign kind = op_kind(op);
  assign mode = mode_t'(op[4:2]);
  assign pc2 = pc + 16'd2;

  always_comb begin
    unique case (cmd.addr_sel)
      A_IN:    maddr = iaddr;
      A_PC:    maddr = pc;
      A_PC1:   maddr = pc + 16'd1;
      A_PC2:   maddr = pc2;
      A_ZP:    maddr = {8'h00, b1};
      A_ZP1:   maddr = {8'h00, 8'(b1 + 8'd1)};
      A_ZPX:   maddr = {8'h00, 8'(b1 + x)};
      A_ZPX1:  maddr = {8'h00, 8'(b1 + x + 8'd1)};
      A_W:     maddr = w;
      A_W1:    maddr = w + 16'd1;
      A_WX:    maddr = w + {8'h00, x};
      A_WY:    maddr = w + {8'h00, y};
      A_STK:   maddr = {STACK_PAGE, sp};
      A_STK1:  maddr = {STACK_PAGE, 8'(sp + 8'd1)};
      A_STK2:  maddr = {STACK_PAGE, 8'(sp + 8'd2)};
      default: maddr = pc;
    endcase
    unique case (cmd.wr_sel)
      WR_PCH:  wdata = pc2[15:8];
      WR_PCL:  wdata = pc2[7:0];
      default: wdata = idata;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_we) mem[maddr[AW-1:0]] <= wdata;
    rdata <= mem[maddr[AW-1:0]];
  end

  always_comb begin
    opnd = (mode == M_IMM) ? b1 : m;
    sum = {1'b0, a} + {1'b0, opnd} + {8'h00, p[F_C]};
    alu = (kind == K_AND) ? (a & opnd) : sum[7:0];
    unique case (kind)
      K_AND, K_ADC:
        len = (mode == M_ABS || mode == M_ABX || mode == M_ABY) ? 16'd3 : 16'd2;
      K_LDA, K_LDX, K_LDY: len = 16'd2;
      default: len = 16'd1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      act <= in_action;
      iaddr <= in_address;
      idata <= in_data;
    end
    if (cmd.ld_op) op <= rdata;
    if (cmd.ld_b1) b1 <= rdata;
    if (cmd.ld_wb) w <= {rdata, b1};
    if (cmd.ld_wl) w <= {rdata, lo};
    if (cmd.ld_lo) lo <= rdata;
    if (cmd.ld_m) m <= rdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a <= '0;
      x <= '0;
      y <= '0;
      p <= '0;
      sp <= SP_RST;
      pc <= START_RST;
      start_addr <= START_RST;
      isp <= SP_RST;
      stopped <= 1'b0;
      bad <= 1'b0;
      rd <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == CFG_START) begin
          start_addr <= cfg_data;
          pc <= cfg_data;
        end else begin
          isp <= cfg_data[7:0];
          sp <= cfg_data[7:0];
        end
      end
      if (cmd.ld_in) begin
        bad <= 1'b0;
        rd <= '0;
      end
      if (cmd.ld_rd) rd <= rdata;
      if (cmd.sp_dec) sp <= sp - 8'd1;
      if (cmd.sp_pop2) sp <= sp + 8'd2;
      unique case (cmd.pc_sel)
        PC_W:    pc <= w;
        PC_RL:   pc <= {rdata, lo};
        PC_RL1:  pc <= {rdata, lo} + 16'd1;
        default: ;
      endcase
      if (cmd.exec) begin
        pc <= pc + len;
        unique case (kind)
          K_AND, K_ADC: begin
            a <= alu;
            p[F_Z] <= (alu == 8'h00);
            p[F_N] <= alu[7];
            if (kind == K_ADC) begin
              p[F_C] <= sum[8];
              p[F_V] <= ~(a[7] ^ opnd[7]) & (a[7] ^ sum[7]);
            end
          end
          K_LDA, K_LDX, K_LDY: begin
            if (kind == K_LDA) a <= b1;
            if (kind == K_LDX) x <= b1;
            if (kind == K_LDY) y <= b1;
            p[F_Z] <= (b1 == 8'h00);
            p[F_N] <= b1[7];
          end
          K_CLC: p[F_C] <= 1'b0;
          K_SEC: p[F_C] <= 1'b1;
          K_CLI: p[F_I] <= 1'b0;
          K_SEI: p[F_I] <= 1'b1;
          K_CLV: p[F_V] <= 1'b0;
          K_CLD: p[F_D] <= 1'b0;
          K_SED: p[F_D] <= 1'b1;
          K_BRK: stopped <= 1'b1;
          K_BAD: bad <= 1'b1;
          default: ;
        endcase
      end
    end
  end

  assign st.action = action_t'(act);
  assign st.kind = kind;
  assign st.mode = mode;
  assign st.stopped = stopped;

  assign cfg_rd = (cfg_idx == CFG_START) ? start_addr : {8'h00, isp};

  always_comb begin
    res.acc = a;
    res.x = x;
    res.y = y;
    res.sp = sp;
    res.pc = pc;
    res.status = p;
    res.status[F_RUN] = ~stopped;
    res.halted = stopped;
    res.bad = bad;
    res.rd = rd;
  end

endmodule

### rtl/cpu6502_subset_core.sv
// A write or ignored word goes straight to the result; a read waits for its memory byte, and
// an execute walks the chain of single-port reads of its opcode (none while halted).
// Throughput: one word at a time; the next is accepted the cycle after the result is taken.
// Reset (rst, synchronous): A X Y flags cleared, PC 0xFFFC, SP 0xFF, not halted.
// Memory contents are not cleared by reset.
// Depends on c6502_pkg, c6502_if, c6502_ctrl, c6502_dp and the defines header.
`include "cpu6502_subset_core_defines.svh"
module cpu6502_subset_core
  import c6502_pkg::*;
#(
  parameter int unsigned MEM_BYTES = MEM_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  c6502_item_if.sink         item,
  c6502_result_if.source     result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cmd_t        cmd;
  stat_t       st;
  res_t        res;
  logic [15:0] cfg_rd;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;
  assign prdata = {16'h0000, cfg_rd};

  c6502_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .st        (st),
    .cmd       (cmd)
  );

  c6502_dp #(.MEM_BYTES(MEM_BYTES)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .in_action  (item.action),
    .in_address (item.mem_address),
    .in_data    (item.mem_data),
    .cfg_we     (cfg_we),
    .cfg_idx    (paddr[2]),
    .cfg_data   (pwdata[15:0]),
    .cfg_rd     (cfg_rd),
    .res        (res)
  );

  assign result.acc_value = res.acc;
  assign result.x_value = res.x;
  assign result.y_value = res.y;
  assign result.stack_value = res.sp;
  assign result.pc_value = res.pc;
  assign result.status_byte = res.status;
  assign result.halted = res.halted;
  assign result.bad_opcode = res.bad;
  assign result.read_data = res.rd;

  `C6502_ASSERT_NXT(a_busy_after_accept, clk, rst, item.valid && item.ready, !item.ready)
  `C6502_ASSERT_IMP(a_run_flag, clk, rst, result.valid, result.halted == !result.status_byte[F_RUN])
  `C6502_ASSERT_IMP(a_bad_not_halted, clk, rst, result.valid && result.bad_opcode, !result.halted)
  `C6502_ASSERT_IMP(a_no_overlap, clk, rst, result.valid, !item.ready)

endmodule

### tb/tb_cpu6502_subset_core.sv
// Self-checking testbench for cpu6502_subset_core: directed table, then random
// programs built so that no unwritten byte is ever read, checked word by word.
// Depends on c6502_pkg, c6502_if and the core RTL.
`timescale 1ns / 100ps
module tb_cpu6502_subset_core;
  import c6502_pkg::*;

  localparam int          LIMIT        = 1000000;
  localparam int          PHASE_WORDS  = 330;
  localparam int          DRAIN_CYC    = 20;
  localparam logic [2:0]  ADDR_START   = 3'd0;
  localparam logic [2:0]  ADDR_SP      = 3'd4;

  typedef struct packed {
    logic [7:0]  a;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  sp;
    logic [15:0] pc;
    logic [7:0]  fl;
    logic        stop;
  } cpu_t;

  typedef struct packed {
    action_t     act;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        chk;
    res_t        r;
  } dir_row_t;

  localparam res_t NO_RES = '0;
  localparam dir_row_t DIR_TAB [0:24] = '{
    '{ACT_NONE, 16'h0000, 8'h00, 1'b1, {8'h00, 8'h00, 8'h00, 8'hFF, 16'hFFFC, 8'h20, 2'b00, 8'h00}},
    '{ACT_WR,   16'hFFFC, OP_LDA, 1'b0, NO_RES},
    '{ACT_WR,   16'hFFFD, 8'h80, 1'b0, NO_RES},
    '{ACT_EXEC, 16'h0000, 8'h00, 1'b1, {8'h80, 8'h00, 8'h00, 8'hFF, 16'hFFFE, 8'hA0, 2'b00, 8'h00}},
    '{ACT_WR,   16'hFFFE, 8'h69, 1'b0, NO_RES},
    '{ACT_WR,   16'hFFFF, 8'h80, 1'b0, NO_RES},
    '{ACT_WR,   16'h0000, OP_SEC, 1'b0, NO_RES},
    '{ACT_EXEC, 16'h0000, 8'h00, 1'b1, {8'h00, 8'h00, 8'h00, 8'hFF, 16'h0000, 8'h63, 2'b00, 8'h00}},
    '{ACT_WR,   16'h0001, 8'h69, 1'b0, NO_RES},
    '{ACT_WR,   16'h0002, 8'h7F, 1'b0, NO_RES},
    '{ACT_WR,   16'h0003, OP_JSR, 1'b0, NO_RES},
    '{ACT_EXEC, 16'h0000, 8'h00, 1'b0, NO_RES},
    '{ACT_EXEC, 16'h0000, 8'h00, 1'b0, NO_RES},
    '{ACT_WR,   16'h0004, 8'h00, 1'b0, NO_RES},
    '{ACT_WR,   16'h0005, 8'h02, 1'b0, NO_RES},
    '{ACT_EXEC, 16'h0000, 8'h00, 1'b0, NO_RES},
    '{ACT_WR,   16'h0200, OP_RTS, 1'b0, NO_RES},
    '{ACT_WR,   16'h0201, OP_NOP, 1'b0, NO_RES},
    '{ACT_EXEC, 16'h0000, 8'h00, 1'b0, NO_RES},
    '{ACT_WR,   16'h0006, 8'hFF, 1'b0, NO_RES},
    '{ACT_WR,   16'h0007, OP_LDX, 1'b0, NO_RES},
    '{ACT_EXEC, 16'h0000, 8'h00, 1'b1, {8'h80, 8'h00, 8'h00, 8'hFF, 16'h0007, 8'hE0, 2'b01, 8'h00}},
    '{ACT_WR,   16'h0008, 8'hFF, 1'b0, NO_RES},
    '{ACT_EXEC, 16'h0000, 8'h00, 1'b0, NO_RES},
    '{ACT_RD,   16'h01FE, 8'h00, 1'b1, {8'h80, 8'hFF, 8'h00, 8'hFF, 16'h0009, 8'hE0, 2'b00, 8'h05}}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  c6502_item_if   item_if();
  c6502_result_if res_if();

  cpu6502_subset_core DUT (
    .clk(clk), .rst(rst), .item(item_if), .result(res_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  cpu_t       cpu;
  logic [7:0] mem_img [0:65535];
  bit         written [0:65535];
  res_t       regfile_q [$];

  // dry-run state: pushes go to a small overlay, first unwritten read is noted
  bit          dry;
  int          miss;
  logic [15:0] ov_a [0:3];
  logic [7:0]  ov_d [0:3];
  int          ov_n;

  int cycles;
  int errors;
  int words_sent;
  int execs_sent;
  int results_seen;
  int burst_left;
  bit quiet_gaps;

  function automatic logic [7:0] rd8(logic [15:0] a);
    for (int i = ov_n - 1; i >= 0; i--)
      if (ov_a[i] == a) return ov_d[i];
    if (!written[a] && miss < 0) miss = a;
    return mem_img[a];
  endfunction

  function automatic void wr8(logic [15:0] a, logic [7:0] v);
    if (dry) begin
      ov_a[ov_n] = a;
      ov_d[ov_n] = v;
      ov_n++;
    end else begin
      mem_img[a] = v;
      written[a] = 1'b1;
    end
  endfunction

  function automatic logic [15:0] word16(logic [15:0] a);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = rd8(a);
    hi = rd8(a + 16'd1);
    return {hi, lo};
  endfunction

  function automatic logic [15:0] zp_word(logic [7:0] p);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = rd8({8'h00, p});
    hi = rd8({8'h00, 8'(p + 8'd1)});
    return {hi, lo};
  endfunction

  function automatic void set_zn(inout cpu_t c, input logic [7:0] v);
    c.fl[F_Z] = (v == 8'h00);
    c.fl[F_N] = v[7];
  endfunction

  function automatic bit is_alu(logic [7:0] op);
    return op[1:0] == GRP_ALU && (op[7:5] == GRP_AND || op[7:5] == GRP_ADC);
  endfunction

  function automatic bit is_known(logic [7:0] op);
    if (is_alu(op)) return 1'b1;
    case (op)
      OP_JMP, OP_JMPI, OP_JSR, OP_RTS, OP_LDA, OP_LDX, OP_LDY, OP_CLC, OP_SEC,
      OP_CLI, OP_SEI, OP_CLV, OP_CLD, OP_SED, OP_NOP, OP_BRK: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // executes the opcode at c.pc, returns 1 on an unknown opcode
  function automatic bit run_opcode(inout cpu_t c);
    logic [15:0] pc;
    logic [15:0] w;
    logic [15:0] ret;
    logic [7:0]  op;
    logic [7:0]  b1;
    logic [7:0]  m;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [8:0]  sum;
    logic [15:0] len;
    pc = c.pc;
    op = rd8(pc);
    b1 = rd8(pc + 16'd1);
    len = 16'd1;
    if (is_alu(op)) begin
      w = word16(pc + 16'd1);
      len = 16'd2;
      case (op[4:0])
        5'h09: m = b1;
        5'h05: m = rd8({8'h00, b1});
        5'h15: m = rd8({8'h00, 8'(b1 + c.x)});
        5'h0D: begin m = rd8(w); len = 16'd3; end
        5'h1D: begin m = rd8(w + 16'(c.x)); len = 16'd3; end
        5'h19: begin m = rd8(w + 16'(c.y)); len = 16'd3; end
        5'h01: m = rd8(zp_word(8'(b1 + c.x)));
        default: m = rd8(zp_word(b1) + 16'(c.y));
      endcase
      if (op[7:5] == GRP_ADC) begin
        sum = {1'b0, c.a} + {1'b0, m} + {8'h00, c.fl[F_C]};
        c.fl[F_C] = sum[8];
        c.fl[F_V] = ~(c.a[7] ^ m[7]) & (c.a[7] ^ sum[7]);
        c.a = sum[7:0];
      end else begin
        c.a = c.a & m;
      end
      set_zn(c, c.a);
      c.pc = pc + len;
      return 1'b0;
    end
    case (op)
      OP_JMP: begin c.pc = word16(pc + 16'd1); return 1'b0; end
      OP_JMPI: begin c.pc = word16(word16(pc + 16'd1)); return 1'b0; end
      OP_JSR: begin
        ret = pc + 16'd2;
        wr8({STACK_PAGE, c.sp}, ret[15:8]);
        c.sp = c.sp - 8'd1;
        wr8({STACK_PAGE, c.sp}, ret[7:0]);
        c.sp = c.sp - 8'd1;
        c.pc = word16(pc + 16'd1);
        return 1'b0;
      end
      OP_RTS: begin
        c.sp = c.sp + 8'd1;
        lo = rd8({STACK_PAGE, c.sp});
        c.sp = c.sp + 8'd1;
        hi = rd8({STACK_PAGE, c.sp});
        c.pc = {hi, lo} + 16'd1;
        return 1'b0;
      end
      OP_LDA: begin c.a = b1; set_zn(c, b1); len = 16'd2; end
      OP_LDX: begin c.x = b1; set_zn(c, b1); len = 16'd2; end
      OP_LDY: begin c.y = b1; set_zn(c, b1); len = 16'd2; end
      OP_CLC: c.fl[F_C] = 1'b0;
      OP_SEC: c.fl[F_C] = 1'b1;
      OP_CLI: c.fl[F_I] = 1'b0;
      OP_SEI: c.fl[F_I] = 1'b1;
      OP_CLV: c.fl[F_V] = 1'b0;
      OP_CLD: c.fl[F_D] = 1'b0;
      OP_SED: c.fl[F_D] = 1'b1;
      OP_NOP: ;
      OP_BRK: c.stop = 1'b1;
      default: begin c.pc = pc + 16'd1; return 1'b1; end
    endcase
    c.pc = pc + len;
    return 1'b0;
  endfunction

  function automatic res_t apply_word(action_t act, logic [15:0] addr, logic [7:0] data);
    res_t r;
    logic [7:0] rdv;
    bit bad;
    rdv = 8'h00;
    bad = 1'b0;
    case (act)
      ACT_WR: wr8(addr, data);
      ACT_RD: rdv = rd8(addr);
      ACT_EXEC: if (!cpu.stop) bad = run_opcode(cpu);
      default: ;
    endcase
    r.acc = cpu.a;
    r.x = cpu.x;
    r.y = cpu.y;
    r.sp = cpu.sp;
    r.pc = cpu.pc;
    r.status = cpu.fl;
    r.status[F_RUN] = ~cpu.stop;
    r.halted = cpu.stop;
    r.bad = bad;
    r.rd = rdv;
    return r;
  endfunction

  // first unwritten address the next execute would read, or -1
  function automatic int unwritten_read();
    cpu_t t;
    t = cpu;
    dry = 1'b1;
    ov_n = 0;
    miss = -1;
    if (!t.stop) void'(run_opcode(t));
    dry = 1'b0;
    ov_n = 0;
    return miss;
  endfunction

  task automatic send_word(action_t act, logic [15:0] addr, logic [7:0] data,
                           bit typed = 1'b0, res_t typed_res = '0);
    int gap;
    res_t r;
    if (burst_left == 0) begin
      gap = quiet_gaps ? 0 : $urandom_range(0, 7);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        item_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    item_if.valid <= 1'b1;
    item_if.action <= act;
    item_if.mem_address <= addr;
    item_if.mem_data <= data;
    @(posedge clk);
    while (!item_if.ready) @(posedge clk);
    r = apply_word(act, addr, data);
    regfile_q.push_back(typed ? typed_res : r);
    burst_left--;
    words_sent++;
    if (words_sent % 200 == 0) quiet_gaps = ~quiet_gaps;
    if (act == ACT_EXEC) execs_sent++;
  endtask

  task automatic wait_idle();
    item_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (regfile_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic apb_write(logic [2:0] a, logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= a;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (a == ADDR_START) cpu.pc = v[15:0];
    else cpu.sp = v[7:0];
  endtask

  task automatic gen_exec(bit allow_brk);
    logic [7:0] op;
    logic [7:0] alu_modes [0:7];
    logic [7:0] flag_ops [0:7];
    int pick;
    int m;
    alu_modes = '{8'h01, 8'h05, 8'h09, 8'h0D, 8'h11, 8'h15, 8'h19, 8'h1D};
    flag_ops = '{OP_CLC, OP_SEC, OP_CLI, OP_SEI, OP_CLV, OP_CLD, OP_SED, OP_NOP};
    pick = $urandom_range(0, 99);
    if (allow_brk) op = OP_BRK;
    else if (pick < 45)
      op = ($urandom_range(0, 1) ? {GRP_ADC, 5'h00} : {GRP_AND, 5'h00})
           | alu_modes[$urandom_range(0, 7)];
    else if (pick < 60) begin
      case ($urandom_range(0, 2))
        0: op = OP_LDA;
        1: op = OP_LDX;
        default: op = OP_LDY;
      endcase
    end else if (pick < 70) op = flag_ops[$urandom_range(0, 7)];
    else if (pick < 76) op = OP_JMP;
    else if (pick < 80) op = OP_JMPI;
    else if (pick < 87) op = OP_JSR;
    else if (pick < 93) op = OP_RTS;
    else begin
      op = 8'($urandom_range(1, 255));
      while (is_known(op)) op = 8'($urandom_range(1, 255));
    end
    send_word(ACT_WR, cpu.pc, op);
    for (int i = 1; i <= 2; i++)
      if ($urandom_range(0, 3) != 0)
        send_word(ACT_WR, cpu.pc + 16'(i), 8'($urandom));
    m = unwritten_read();
    while (m >= 0) begin
      send_word(ACT_WR, 16'(m), 8'($urandom));
      m = unwritten_read();
    end
    send_word(ACT_EXEC, 16'($urandom), 8'($urandom));
  endtask

  task automatic gen_word();
    int pick;
    logic [15:0] a;
    pick = $urandom_range(0, 99);
    a = 16'($urandom);
    if (pick < 8) send_word(ACT_NONE, a, 8'($urandom));
    else if (pick < 18) begin
      if (!written[a]) send_word(ACT_WR, a, 8'($urandom));
      send_word(ACT_RD, a, 8'($urandom));
    end else if (pick < 26) send_word(ACT_WR, a, 8'($urandom));
    else gen_exec(1'b0);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // receiver stall pattern: open, random, then a fixed duty cycle
  always @(posedge clk) begin
    if (rst) res_if.ready <= 1'b0;
    else begin
      case ((cycles / 256) % 3)
        0: res_if.ready <= 1'b1;
        1: res_if.ready <= $urandom_range(0, 1);
        default: res_if.ready <= (cycles % 8) >= 3;
      endcase
    end
  end

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      got = {res_if.acc_value, res_if.x_value, res_if.y_value, res_if.stack_value,
             res_if.pc_value, res_if.status_byte, res_if.halted, res_if.bad_opcode,
             res_if.read_data};
      results_seen++;
      if (regfile_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %h", got);
      end else begin
        want = regfile_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch #%0d: exp a=%h x=%h y=%h sp=%h pc=%h st=%h h=%b bad=%b ",
                      "rd=%h | got a=%h x=%h y=%h sp=%h pc=%h st=%h h=%b bad=%b rd=%h"},
                     results_seen, want.acc, want.x, want.y, want.sp, want.pc, want.status,
                     want.halted, want.bad, want.rd, got.acc, got.x, got.y, got.sp, got.pc,
                     got.status, got.halted, got.bad, got.rd);
        end
      end
    end
  end

  initial begin
    logic [15:0] starts [0:4];
    logic [7:0]  sps [0:4];
    int m;
    item_if.valid = 1'b0;
    item_if.action = ACT_NONE;
    item_if.mem_address = '0;
    item_if.mem_data = '0;
    cycles = 0;
    errors = 0;
    words_sent = 0;
    execs_sent = 0;
    results_seen = 0;
    burst_left = 0;
    quiet_gaps = 1'b0;
    dry = 1'b0;
    ov_n = 0;
    miss = -1;
    for (int i = 0; i < 65536; i++) begin
      mem_img[i] = 8'h00;
      written[i] = 1'b0;
    end
    cpu = '{a: 8'h00, x: 8'h00, y: 8'h00, sp: SP_RST, pc: START_RST, fl: 8'h00, stop: 1'b0};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIR_TAB[i])
      send_word(DIR_TAB[i].act, DIR_TAB[i].addr, DIR_TAB[i].data, DIR_TAB[i].chk,
                DIR_TAB[i].r);

    starts = '{16'h0000, 16'hFFFF, 16'($urandom), 16'($urandom), 16'hFFFD};
    sps = '{8'h00, 8'hFF, 8'($urandom), 8'h01, 8'($urandom)};
    for (int p = 0; p < 5; p++) begin
      wait_idle();
      apb_write(ADDR_START, {16'h0000, starts[p]});
      apb_write(ADDR_SP, {24'h000000, sps[p]});
      m = words_sent + PHASE_WORDS;
      while (words_sent < m) gen_word();
    end

    // halt: BRK, then an execute that must change nothing, then read back the BRK byte
    gen_exec(1'b1);
    send_word(ACT_EXEC, 16'h0000, 8'h00);
    send_word(ACT_RD, cpu.pc - 16'd1, 8'h00);
    item_if.valid <= 1'b0;

    while (regfile_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (regfile_q.size() != 0) errors++;
    $display("covered %0d words (%0d executes) over 5 register settings, %0d results checked",
             words_sent, execs_sent, results_seen);
    $display("mismatches: %0d", errors);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/c6502_pkg.sv
rtl/c6502_if.sv
rtl/c6502_ctrl.sv
rtl/c6502_dp.sv
rtl/cpu6502_subset_core.sv
tb/tb_cpu6502_subset_core.sv
